@@ rtl/core/alcw_pkg.sv @@
// Shared types and constants for the aspect-locked crop window core.
// Depends on nothing; used by aspect_locked_crop_window_core.
package alcw_pkg;

   localparam int MIN_SIZE_DEF = 16;     // smallest side a scale may leave
   localparam int DIM_MAX      = 16384;  // largest usable image side
   localparam int EDGE_MAX     = 16383;  // largest left or top edge
   localparam int DIV_BITS     = 28;     // dividend width of the rounding divider

   localparam int CSR_AW = 4;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_RATIO_WIDTH  = 2'd2,
      CSR_RATIO_HEIGHT = 2'd3
   } csr_index_type;

   // CMD_INIT doubles as "no previous action" in the repeat record.
   typedef enum logic [2:0] {
      CMD_INIT   = 3'd0,
      CMD_GROW   = 3'd1,
      CMD_SHRINK = 3'd2,
      CMD_LEFT   = 3'd3,
      CMD_DOWN   = 3'd4,
      CMD_UP     = 3'd5,
      CMD_RIGHT  = 3'd6,
      CMD_REPEAT = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_PREP,
      ST_DIV,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/aspect_locked_crop_window_core.sv @@
// Aspect-locked crop window: command sequencer with one shared multiplier
// and a bit-serial rounding divider. Depends on alcw_pkg.
//
//  channel | direction | beat contents
//  req_    | in        | tdata: step[13:0]; tuser: req_type[2:0]
//  rsp_    | out       | tdata: win_x, win_y, win_width, win_height; tuser: refused
//  csr_    | in/out    | APB registers at 0x0, 0x4, 0x8, 0xC
//
// An init, a grow or a shrink runs the 28-step restoring divider; a scale
// refused on its height still runs the whole divider. Moves skip the divider,
// and a repeat with no record or a scale refused on its width goes from decode
// straight to done. req_tready is high only while the
// sequencer is idle. A finished window waits in the output register, and the
// next command may start meanwhile but holds its result until the output
// register is free. Reset is synchronous and restores the register
// defaults and a 0x0 window at the origin.
module aspect_locked_crop_window_core #(
   parameter int MIN_SIZE = alcw_pkg::MIN_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,   // step[13:0], zero pad
   input  logic [2:0]                  req_tuser,   // req_type[2:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // win_x[13:0], win_y[27:14], win_width[42:28], win_height[57:43], zero pad
   output logic [63:0]                 rsp_tdata,
   output logic [0:0]                  rsp_tuser,   // refused[0]
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [alcw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam logic [15:0] MinSize  = 16'(MIN_SIZE);
   localparam logic [14:0] DimMax   = 15'(alcw_pkg::DIM_MAX);
   localparam int          DB       = alcw_pkg::DIV_BITS;
   localparam logic [4:0]  DivLast  = 5'(alcw_pkg::DIV_BITS - 1);

   // Configuration registers.
   logic [14:0] image_width_ff, image_height_ff;
   logic [11:0] ratio_width_ff, ratio_height_ff;

   // Window state and repeat record.
   logic [13:0] cur_x_ff, cur_y_ff;
   logic [14:0] cur_width_ff, cur_height_ff;
   alcw_pkg::cmd_type prev_kind_ff;
   logic [13:0] prev_step_ff;

   // Command in flight.
   alcw_pkg::state_type state_ff, state_in;
   alcw_pkg::cmd_type op_kind_ff;
   logic [13:0] op_step_ff;
   logic        refused_ff;
   logic        pin_height_ff;

   // Shared arithmetic.
   logic [14:0] a_ff;
   logic [11:0] b_ff, c_ff;
   logic [26:0] prod_ff;
   logic [DB-1:0] quo_ff;
   logic [12:0] rem_ff, den_ff;
   logic [4:0]  cnt_ff;

   // Output register.
   logic        rsp_tvalid_ff;
   logic [63:0] rsp_tdata_ff;
   logic        rsp_refused_ff;

   logic [14:0] iw, ih;
   logic [11:0] aw, ah;
   logic [14:0] mul_a;
   logic [11:0] mul_b;
   logic [26:0] mul_p;
   logic [15:0] new_width;
   logic        scale_reject, nh_reject;
   logic [13:0] rem_shift;
   logic        csr_write, req_accept, rsp_load, out_free;
   alcw_pkg::cmd_type req_kind;
   logic [14:0] init_w, init_h;
   logic signed [17:0] pos_x, pos_y;
   logic [13:0] clamp_x, clamp_y;
   logic [14:0] size_x, size_y;

   // Keeps a window edge inside [0, lim - sz] and below the edge limit.
   function automatic logic [13:0] clamp_edge(input logic signed [17:0] pos,
                                              input logic [14:0] sz,
                                              input logic [14:0] lim);
      logic signed [17:0] hi;
      logic signed [17:0] p;
      hi = signed'({3'b000, lim}) - signed'({3'b000, sz});
      p  = (pos < 0) ? 18'sd0 : pos;
      if (p > hi) begin
         p = hi;
      end
      if (p < 0) begin
         p = 18'sd0;
      end
      if (p > 18'sd16383) begin
         p = 18'sd16383;
      end
      return p[13:0];
   endfunction

   // Effective image sides and ratio terms.
   always_comb begin
      iw = (image_width_ff == 15'd0) ? 15'd1 :
           (image_width_ff > DimMax) ? DimMax : image_width_ff;
      ih = (image_height_ff == 15'd0) ? 15'd1 :
           (image_height_ff > DimMax) ? DimMax : image_height_ff;
      aw = (ratio_width_ff == 12'd0) ? 12'd1 : ratio_width_ff;
      ah = (ratio_height_ff == 12'd0) ? 12'd1 : ratio_height_ff;
   end

   // The one multiplier, shared by the ratio compare and the numerator.
   always_comb begin
      unique case (state_ff)
         alcw_pkg::ST_MUL1: begin
            mul_a = iw;
            mul_b = ah;
         end
         alcw_pkg::ST_MUL2: begin
            mul_a = ih;
            mul_b = aw;
         end
         default: begin
            mul_a = a_ff;
            mul_b = b_ff;
         end
      endcase
      mul_p = 27'(mul_a) * 27'(mul_b);
   end

   assign req_kind = alcw_pkg::cmd_type'(req_tuser);

   // Width change of a scale, refused early when out of range, and the later height check on the quotient.
   always_comb begin
      if (op_kind_ff == alcw_pkg::CMD_GROW) begin
         new_width = {1'b0, cur_width_ff} + {2'b00, op_step_ff};
      end else begin
         new_width = {1'b0, cur_width_ff} - {2'b00, op_step_ff};
      end
      scale_reject = (op_kind_ff == alcw_pkg::CMD_SHRINK && op_step_ff > cur_width_ff[13:0]
                      && cur_width_ff[14] == 1'b0)
                     || new_width < MinSize || new_width > {1'b0, iw};
      nh_reject = quo_ff < DB'(MinSize) || quo_ff > DB'(ih);
   end

   assign rem_shift = {rem_ff, quo_ff[DB-1]};

   // Window derived by init from the quotient.
   always_comb begin
      if (pin_height_ff) begin
         init_h = ih;
         init_w = (quo_ff > DB'(iw)) ? iw : quo_ff[14:0];
      end else begin
         init_w = iw;
         init_h = (quo_ff > DB'(ih)) ? ih : quo_ff[14:0];
      end
   end

   // Edge positions before clamping, for moves and scales.
   always_comb begin
      pos_x  = signed'({4'b0000, cur_x_ff});
      pos_y  = signed'({4'b0000, cur_y_ff});
      size_x = cur_width_ff;
      size_y = cur_height_ff;
      case (op_kind_ff)
         alcw_pkg::CMD_LEFT:  pos_x = pos_x - signed'({4'b0000, op_step_ff});
         alcw_pkg::CMD_RIGHT: pos_x = pos_x + signed'({4'b0000, op_step_ff});
         alcw_pkg::CMD_UP:    pos_y = pos_y - signed'({4'b0000, op_step_ff});
         alcw_pkg::CMD_DOWN:  pos_y = pos_y + signed'({4'b0000, op_step_ff});
         alcw_pkg::CMD_GROW, alcw_pkg::CMD_SHRINK: begin
            // Keep the centre: old edge plus half the old size, less half the new.
            pos_x = pos_x + signed'({4'b0000, cur_width_ff[14:1]})
                    - signed'({4'b0000, a_ff[14:1]});
            pos_y = pos_y + signed'({4'b0000, cur_height_ff[14:1]})
                    - signed'({4'b0000, quo_ff[14:1]});
            size_x = a_ff;
            size_y = quo_ff[14:0];
         end
         default: begin
         end
      endcase
      clamp_x = clamp_edge(pos_x, size_x, iw);
      clamp_y = clamp_edge(pos_y, size_y, ih);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alcw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = alcw_pkg::ST_DECODE;
            end
         end
         alcw_pkg::ST_DECODE: begin
            if (refused_ff) begin
               state_in = alcw_pkg::ST_DONE;
            end else begin
               case (op_kind_ff)
                  alcw_pkg::CMD_INIT: state_in = alcw_pkg::ST_MUL1;
                  alcw_pkg::CMD_GROW, alcw_pkg::CMD_SHRINK:
                     state_in = scale_reject ? alcw_pkg::ST_DONE : alcw_pkg::ST_MUL3;
                  default: state_in = alcw_pkg::ST_APPLY;
               endcase
            end
         end
         alcw_pkg::ST_MUL1: state_in = alcw_pkg::ST_MUL2;
         alcw_pkg::ST_MUL2: state_in = alcw_pkg::ST_MUL3;
         alcw_pkg::ST_MUL3: state_in = alcw_pkg::ST_PREP;
         alcw_pkg::ST_PREP: state_in = alcw_pkg::ST_DIV;
         alcw_pkg::ST_DIV: begin
            if (cnt_ff == DivLast) begin
               state_in = alcw_pkg::ST_APPLY;
            end
         end
         alcw_pkg::ST_APPLY: state_in = alcw_pkg::ST_DONE;
         alcw_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = alcw_pkg::ST_IDLE;
            end
         end
         default: state_in = alcw_pkg::ST_IDLE;
      endcase
   end

   // Handshake strobes.
   always_comb begin
      out_free   = !rsp_tvalid_ff || rsp_tready;
      req_tready = (state_ff == alcw_pkg::ST_IDLE);
      req_accept = req_tvalid && req_tready;
      rsp_load   = (state_ff == alcw_pkg::ST_DONE) && out_free;
      csr_write  = csr_psel && csr_penable && csr_pwrite;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= alcw_pkg::ST_IDLE;
         image_width_ff  <= 15'd1920;
         image_height_ff <= 15'd1080;
         ratio_width_ff  <= 12'd16;
         ratio_height_ff <= 12'd9;
         cur_x_ff        <= '0;
         cur_y_ff        <= '0;
         cur_width_ff    <= '0;
         cur_height_ff   <= '0;
         prev_kind_ff    <= alcw_pkg::CMD_INIT;
         prev_step_ff    <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write) begin
            unique case (alcw_pkg::csr_index_type'(csr_paddr[3:2]))
               alcw_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[14:0];
               alcw_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[14:0];
               alcw_pkg::CSR_RATIO_WIDTH:  ratio_width_ff  <= csr_pwdata[11:0];
               alcw_pkg::CSR_RATIO_HEIGHT: ratio_height_ff <= csr_pwdata[11:0];
               default: begin
               end
            endcase
         end

         // Moves and scales are recorded even when refused.
         if (req_accept && req_kind != alcw_pkg::CMD_INIT
             && req_kind != alcw_pkg::CMD_REPEAT) begin
            prev_kind_ff <= req_kind;
            prev_step_ff <= req_tdata[13:0];
         end

         if (state_ff == alcw_pkg::ST_APPLY) begin
            case (op_kind_ff)
               alcw_pkg::CMD_INIT: begin
                  cur_width_ff  <= init_w;
                  cur_height_ff <= init_h;
                  cur_x_ff      <= 14'((iw - init_w) >> 1);
                  cur_y_ff      <= 14'((ih - init_h) >> 1);
               end
               alcw_pkg::CMD_GROW, alcw_pkg::CMD_SHRINK: begin
                  if (!nh_reject) begin
                     cur_width_ff  <= a_ff;
                     cur_height_ff <= quo_ff[14:0];
                     cur_x_ff      <= clamp_x;
                     cur_y_ff      <= clamp_y;
                  end
               end
               default: begin
                  cur_x_ff <= clamp_x;
                  cur_y_ff <= clamp_y;
               end
            endcase
         end

         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      case (state_ff)
         alcw_pkg::ST_IDLE: begin
            if (req_accept) begin
               // A repeat takes over the recorded command; with none it is refused.
               if (req_kind == alcw_pkg::CMD_REPEAT) begin
                  op_kind_ff <= prev_kind_ff;
                  op_step_ff <= prev_step_ff;
                  refused_ff <= (prev_kind_ff == alcw_pkg::CMD_INIT);
               end else begin
                  op_kind_ff <= req_kind;
                  op_step_ff <= req_tdata[13:0];
                  refused_ff <= 1'b0;
               end
            end
         end
         alcw_pkg::ST_DECODE: begin
            if ((op_kind_ff == alcw_pkg::CMD_GROW || op_kind_ff == alcw_pkg::CMD_SHRINK)
                && scale_reject) begin
               refused_ff <= 1'b1;
            end
            a_ff <= new_width[14:0];
            b_ff <= ah;
            c_ff <= aw;
         end
         alcw_pkg::ST_MUL1: prod_ff <= mul_p;
         alcw_pkg::ST_MUL2: begin
            // Wider image than the ratio: the height is pinned to the image.
            if (prod_ff > mul_p) begin
               pin_height_ff <= 1'b1;
               a_ff <= ih;
               b_ff <= aw;
               c_ff <= ah;
            end else begin
               pin_height_ff <= 1'b0;
               a_ff <= iw;
               b_ff <= ah;
               c_ff <= aw;
            end
         end
         alcw_pkg::ST_MUL3: prod_ff <= mul_p;
         alcw_pkg::ST_PREP: begin
            // Half-up rounding: (2ab + c) / 2c.
            quo_ff <= {prod_ff, 1'b0} + DB'(c_ff);
            den_ff <= {c_ff, 1'b0};
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         alcw_pkg::ST_DIV: begin
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_ff <= 13'(rem_shift - {1'b0, den_ff});
               quo_ff <= {quo_ff[DB-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift[12:0];
               quo_ff <= {quo_ff[DB-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
         end
         alcw_pkg::ST_APPLY: begin
            if ((op_kind_ff == alcw_pkg::CMD_GROW || op_kind_ff == alcw_pkg::CMD_SHRINK)
                && nh_reject) begin
               refused_ff <= 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_tdata_ff   <= {6'b000000, cur_height_ff, cur_width_ff, cur_y_ff, cur_x_ff};
         rsp_refused_ff <= refused_ff;
      end
   end

   // Register read-back.
   always_comb begin
      unique case (alcw_pkg::csr_index_type'(csr_paddr[3:2]))
         alcw_pkg::CSR_IMAGE_WIDTH:  csr_prdata = {17'd0, image_width_ff};
         alcw_pkg::CSR_IMAGE_HEIGHT: csr_prdata = {17'd0, image_height_ff};
         alcw_pkg::CSR_RATIO_WIDTH:  csr_prdata = {20'd0, ratio_width_ff};
         alcw_pkg::CSR_RATIO_HEIGHT: csr_prdata = {20'd0, ratio_height_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_refused_ff;

endmodule
